@@ design/microprogram_control_unit_core_defines.svh @@
// assertion macros for the microprogram control unit checker
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef MICROPROGRAM_CONTROL_UNIT_CORE_DEFINES_SVH
`define MICROPROGRAM_CONTROL_UNIT_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define MCU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define MCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define MCU_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mcu_pkg.sv @@
// shared types, codes and helpers for the microprogram control unit
// no dependencies
package mcu_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ADDR_W      = 8;
    localparam int WORD_W      = 32;
    localparam int SEL_W       = 4;
    localparam int ONEHOT_W    = 16;

    // one past the last store address, wide enough to hold the depth itself
    localparam logic [ADDR_W:0] STORE_LIMIT = (ADDR_W+1)'(STORE_DEPTH);

    // operation codes
    localparam logic [1:0] OP_STEP     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_PC_RESET = 2'd2;

    // subcycle numbers that do work
    localparam logic [2:0] SUB_FETCH   = 3'd1;
    localparam logic [2:0] SUB_BUS     = 3'd2;
    localparam logic [2:0] SUB_ADVANCE = 3'd4;

    // branch conditions
    localparam logic [1:0] COND_NONE   = 2'd0;
    localparam logic [1:0] COND_NEG    = 2'd1;
    localparam logic [1:0] COND_ZERO   = 2'd2;
    localparam logic [1:0] COND_ALWAYS = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [2:0]        subcycle;
        logic              n_flag;
        logic              z_flag;
        logic [ADDR_W-1:0] store_address;
        logic [WORD_W-1:0] store_word;
    } t_in_item;

    typedef struct packed {
        logic                amux;
        logic [1:0]          alu_op;
        logic [1:0]          shift_op;
        logic                mbr_load;
        logic                mar_load;
        logic                mem_read;
        logic                mem_write;
        logic [ONEHOT_W-1:0] a_enable;
        logic [ONEHOT_W-1:0] b_enable;
        logic [ONEHOT_W-1:0] c_enable;
        logic [ADDR_W-1:0]   micro_pc_now;
    } t_out_item;

    // control store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
    } t_store_wr;

    // microword bit 0 is word bit 31
    function automatic logic [1:0] mw_cond(input logic [WORD_W-1:0] w);
        mw_cond = w[30:29];
    endfunction

    function automatic logic mw_enc(input logic [WORD_W-1:0] w);
        mw_enc = w[20];
    endfunction

    function automatic logic [SEL_W-1:0] mw_c(input logic [WORD_W-1:0] w);
        mw_c = w[19:16];
    endfunction

    function automatic logic [SEL_W-1:0] mw_b(input logic [WORD_W-1:0] w);
        mw_b = w[15:12];
    endfunction

    function automatic logic [SEL_W-1:0] mw_a(input logic [WORD_W-1:0] w);
        mw_a = w[11:8];
    endfunction

    function automatic logic [ADDR_W-1:0] mw_addr(input logic [WORD_W-1:0] w);
        mw_addr = w[7:0];
    endfunction

    function automatic logic [ONEHOT_W-1:0] one_hot(input logic [SEL_W-1:0] sel);
        one_hot = ONEHOT_W'(1) << sel;
    endfunction

endpackage

@@ design/mcu_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module mcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/mcu_store.sv @@
// control store: ram plus per-entry valid bits and write-to-read forwarding
// depends on mcu_pkg and mcu_ram
module mcu_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mcu_pkg::t_store_wr        i_wr,
    input  logic [mcu_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [mcu_pkg::WORD_W-1:0] o_rd_word
);
    import mcu_pkg::*;

    logic                wr_in_range;
    logic                rd_in_range;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_idx;
    logic [STORE_AW-1:0] rd_idx;
    logic [WORD_W-1:0]   ram_q;

    logic [STORE_DEPTH-1:0] r_valid;
    logic                   r_rd_valid;
    logic                   r_hit;
    logic [WORD_W-1:0]      r_hit_word;

    assign wr_in_range = {1'b0, i_wr.addr} < STORE_LIMIT;
    assign rd_in_range = {1'b0, i_rd_addr} < STORE_LIMIT;
    assign wr_idx      = i_wr.addr[STORE_AW-1:0];
    assign rd_idx      = i_rd_addr[STORE_AW-1:0];
    assign wr_en       = i_wr.en && wr_in_range;

    mcu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (i_wr.word),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
            r_rd_valid <= rd_in_range && r_valid[rd_idx];
            r_hit      <= wr_en && rd_in_range && (wr_idx == rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_word <= i_wr.word;
    end

    // never-written entries read as zero
    assign o_rd_word = r_hit      ? r_hit_word :
                       r_rd_valid ? ram_q      : '0;

endmodule

@@ design/mcu_seq.sv @@
// sequencer state: micro-instruction, micro-pc and held bus enables
// depends on mcu_pkg
module mcu_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  mcu_pkg::t_in_item          i_item,
    input  logic [mcu_pkg::WORD_W-1:0] i_store_word,
    output mcu_pkg::t_store_wr         o_store_wr,
    output logic [mcu_pkg::ADDR_W-1:0] o_pc_next,
    output mcu_pkg::t_out_item         o_result
);
    import mcu_pkg::*;

    logic [WORD_W-1:0]   r_mi;
    logic [ADDR_W-1:0]   r_pc;
    logic [ONEHOT_W-1:0] r_a;
    logic [ONEHOT_W-1:0] r_b;
    logic [ONEHOT_W-1:0] r_c;

    logic [WORD_W-1:0]   n_mi;
    logic [ADDR_W-1:0]   n_pc;
    logic [ONEHOT_W-1:0] n_a;
    logic [ONEHOT_W-1:0] n_b;
    logic [ONEHOT_W-1:0] n_c;
    logic                jump;

    always_comb begin
        unique case (mw_cond(r_mi))
            COND_ALWAYS: jump = 1'b1;
            COND_ZERO:   jump = i_item.z_flag;
            COND_NEG:    jump = i_item.n_flag;
            default:     jump = 1'b0;
        endcase
    end

    always_comb begin
        n_mi       = r_mi;
        n_pc       = r_pc;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        o_store_wr = '0;
        if (i_advance) begin
            unique case (i_item.operation)
                OP_STEP: begin
                    unique case (i_item.subcycle)
                        SUB_FETCH: begin
                            n_mi = i_store_word;
                        end
                        SUB_BUS: begin
                            n_a = one_hot(mw_a(r_mi));
                            n_b = one_hot(mw_b(r_mi));
                        end
                        SUB_ADVANCE: begin
                            n_c  = mw_enc(r_mi) ? one_hot(mw_c(r_mi)) : '0;
                            n_pc = jump ? mw_addr(r_mi) : r_pc + ADDR_W'(1);
                        end
                        default: ;
                    endcase
                end
                OP_WRITE: begin
                    o_store_wr.en   = 1'b1;
                    o_store_wr.addr = i_item.store_address;
                    o_store_wr.word = i_item.store_word;
                end
                OP_PC_RESET: begin
                    n_pc = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mi <= '0;
            r_pc <= '0;
            r_a  <= '0;
            r_b  <= '0;
            r_c  <= '0;
        end else begin
            r_mi <= n_mi;
            r_pc <= n_pc;
            r_a  <= n_a;
            r_b  <= n_b;
            r_c  <= n_c;
        end
    end

    assign o_pc_next = n_pc;

    always_comb begin
        o_result.amux         = n_mi[31];
        o_result.alu_op       = n_mi[28:27];
        o_result.shift_op     = n_mi[26:25];
        o_result.mbr_load     = n_mi[24];
        o_result.mar_load     = n_mi[23];
        o_result.mem_read     = n_mi[22];
        o_result.mem_write    = n_mi[21];
        o_result.a_enable     = n_a;
        o_result.b_enable     = n_b;
        o_result.c_enable     = n_c;
        o_result.micro_pc_now = n_pc;
    end

endmodule

@@ design/microprogram_control_unit_core.sv @@
// microprogram control unit top level: input stage, sequencer, store, result stage
// depends on mcu_pkg, mcu_seq, mcu_store
//
// usage
//   input channel (i_in_valid / o_in_stall / i_in) carries one request per
//   accepted edge: a step of one clock subcycle, a control store write, or a
//   micro-pc reset
//   output channel (o_out_valid / i_out_stall / o_out) returns exactly one
//   result per request: control bits of the micro-instruction register, the
//   held one-hot a/b/c enables and the micro-pc after the request
// timing
//   a request waits in the input register, where the sequencer and the store
//   forwarding evaluate it; its result is registered in the output register
//   as it leaves; throughput is one request per cycle unless i_out_stall
//   holds a result; the store is read every cycle at the next micro-pc so a
//   fetch always sees the latest pc and any write just made
// reset
//   synchronous, active low; valid flags, sequencer state and the 256 store
//   valid bits clear at once, so the store reads zero words with no clearing pass
// backpressure
//   while i_out_stall holds a waiting result, the input register still takes
//   one more request; o_in_stall rises only when both registers are full
module microprogram_control_unit_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mcu_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mcu_pkg::t_out_item  o_out
);
    import mcu_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_item  r_in;
    // result register
    logic      r_out_valid;
    t_out_item r_out;

    logic              accept;
    logic              advance;
    t_store_wr         store_wr;
    logic [ADDR_W-1:0] pc_next;
    logic [WORD_W-1:0] store_word;
    t_out_item         result;

    // the held request moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // sequencer state advances only when a request leaves the input register
    mcu_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in),
        .i_store_word (store_word),
        .o_store_wr   (store_wr),
        .o_pc_next    (pc_next),
        .o_result     (result)
    );

    // read port follows the next pc so the word at the current pc is ready
    mcu_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_addr (pc_next),
        .o_rd_word (store_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/mcu_checker.sv @@
// port-level checks for the microprogram control unit, bound to the top level
// depends on mcu_pkg and microprogram_control_unit_core_defines.svh
`include "microprogram_control_unit_core_defines.svh"

module mcu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mcu_pkg::t_out_item o_out
);
    import mcu_pkg::*;

    // held enables come from a 4-bit field decode, so at most one bit is set
    `MCU_ASSERT_NOW(a_en_onehot, o_out_valid, $onehot0(o_out.a_enable), "a_enable not one-hot")
    `MCU_ASSERT_NOW(c_en_onehot, o_out_valid, $onehot0(o_out.c_enable), "c_enable not one-hot")

    // a result stalled by the receiver stays offered
    `MCU_ASSERT_NEXT(out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")

    // no result shows right after reset
    `MCU_ASSERT_RESET(out_reset, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind microprogram_control_unit_core mcu_checker u_mcu_checker (.*);
